[rtl/core/tqla_pkg.sv]
package tqla_pkg;

  // Table geometry and number formats.
  localparam int NUM_STATES = 64;
  localparam int Q_WIDTH    = 32;
  localparam int ACTIONS    = 4;
  localparam int ACT_W      = 2;
  localparam int IDX_W      = 6;
  localparam int RWD_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int OUTQ_W     = 32;

  // Stored entry width, held within the supported range.
  localparam int QW    = (Q_WIDTH < 16) ? 16 : ((Q_WIDTH > 62) ? 62 : Q_WIDTH);
  localparam int SW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int AW    = SW + ACT_W;
  localparam int DEPTH = NUM_STATES * ACTIONS;
  // Width of target and delta: room for reward plus a scaled entry minus an entry.
  localparam int DW    = ((QW > RWD_W) ? QW : RWD_W) + 4;

  localparam logic [31:0] LFSR_TAPS = 32'hA300_0000;

  localparam logic [FRAC_W-1:0] LR_RESET   = 16'd6554;
  localparam logic [FRAC_W-1:0] DISC_RESET = 16'd58982;
  localparam logic [FRAC_W-1:0] THR_RESET  = 16'd6554;
  localparam logic [31:0]       SEED_RESET = 32'd1;

  typedef enum logic [1:0] {
    CFG_LEARNING_RATE,
    CFG_DISCOUNT,
    CFG_EXPLORE_THRESHOLD,
    CFG_RNG_SEED
  } cfg_reg_t;

  typedef struct packed {
    logic                    do_update;
    logic [IDX_W-1:0]        state_index;
    logic [ACT_W-1:0]        action_taken;
    logic signed [RWD_W-1:0] reward;
    logic [IDX_W-1:0]        next_state_index;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]         chosen_action;
    logic                     explored;
    logic signed [OUTQ_W-1:0] new_q_value;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_RDQ,
    S_MUL1,
    S_DELTA,
    S_MUL2,
    S_WRITE,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic             load_in;
    logic             lfsr_step;
    logic             rd_en;
    logic             rd_q;
    logic [ACT_W-1:0] rd_slot;
    logic             cap_en;
    logic [ACT_W-1:0] cap_slot;
    logic             cap_q;
    logic             mul1;
    logic             calc_delta;
    logic             mul2;
    logic             wr_en;
    logic             load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic do_update;
    logic out_free;
  } dp_status_t;

  // Fold a state index onto the table rows; a small constant table.
  function automatic logic [SW-1:0] row_wrap(input logic [IDX_W-1:0] idx);
    logic [SW-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << IDX_W); i++) begin
      if (idx == IDX_W'(i)) r = SW'(i % NUM_STATES);
    end
    return r;
  endfunction

  // Galois LFSR, right shift.
  function automatic logic [31:0] lfsr_next(input logic [31:0] s);
    logic [31:0] n;
    n = s >> 1;
    if (s[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

  // Low bits of the sign-extended entry.
  function automatic logic signed [OUTQ_W-1:0] q_to_out(input logic signed [QW-1:0] q);
    logic signed [QW+OUTQ_W-1:0] e;
    e = (QW+OUTQ_W)'(q);
    return e[OUTQ_W-1:0];
  endfunction

endpackage

[rtl/core/tqla_ctrl.sv]
module tqla_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  tqla_pkg::dp_status_t   sts,
  output tqla_pkg::ctrl_cmd_t    cmd
);
  import tqla_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  state_nxt = in_valid ? S_RD0 : S_IDLE;
      S_RD0:   state_nxt = S_RD1;
      S_RD1:   state_nxt = S_RD2;
      S_RD2:   state_nxt = S_RD3;
      S_RD3:   state_nxt = S_RDQ;
      S_RDQ:   state_nxt = S_MUL1;
      S_MUL1:  state_nxt = sts.do_update ? S_DELTA : S_OUT;
      S_DELTA: state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_OUT;
      S_OUT:   state_nxt = sts.out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      S_RD0: begin
        cmd.lfsr_step = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_slot   = 2'd0;
      end
      S_RD1: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_slot  = 2'd1;
        cmd.cap_en   = 1'b1;
        cmd.cap_slot = 2'd0;
      end
      S_RD2: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_slot  = 2'd2;
        cmd.cap_en   = 1'b1;
        cmd.cap_slot = 2'd1;
      end
      S_RD3: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_slot  = 2'd3;
        cmd.cap_en   = 1'b1;
        cmd.cap_slot = 2'd2;
      end
      S_RDQ: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_q     = 1'b1;
        cmd.cap_en   = 1'b1;
        cmd.cap_slot = 2'd3;
      end
      S_MUL1: begin
        cmd.cap_q = 1'b1;
        cmd.mul1  = 1'b1;
      end
      S_DELTA: cmd.calc_delta = 1'b1;
      S_MUL2:  cmd.mul2 = 1'b1;
      S_WRITE: cmd.wr_en = 1'b1;
      S_OUT:   cmd.load_out = sts.out_free;
      default: cmd = '0;
    endcase
  end

  // An accepted transfer always starts the row read.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_RD0))
    else $error("accepted item did not start the row read");

  // The table is only written for an item that asks for an update.
  a_write_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> sts.do_update)
    else $error("table write without an update request");

  // The second multiply always follows the delta step.
  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL2) |-> ($past(state_r) == S_DELTA))
    else $error("second multiply entered out of order");

  // Loading the result frees the engine for the next item.
  a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (state_r == S_IDLE))
    else $error("engine did not return to idle after the result");

endmodule

[rtl/core/tqla_dp.sv]
module tqla_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tqla_pkg::in_item_t    in_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  tqla_pkg::ctrl_cmd_t   cmd,
  output tqla_pkg::dp_status_t  sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tqla_pkg::out_item_t   out_data
);
  import tqla_pkg::*;

  in_item_t                in_r;
  logic [FRAC_W-1:0]       lr_r;
  logic [FRAC_W-1:0]       disc_r;
  logic [FRAC_W-1:0]       thr_r;
  logic [31:0]             lfsr_r;

  logic signed [QW-1:0]    mem [DEPTH];
  logic                    vld_r [DEPTH];
  logic signed [QW-1:0]    rd_data_r;
  logic                    rd_vld_r;

  logic signed [QW-1:0]    cache_r [ACTIONS];
  logic signed [QW-1:0]    mx_r;
  logic signed [QW-1:0]    q_r;
  logic signed [QW+FRAC_W:0] p1_r;
  logic signed [DW-1:0]    delta_r;
  logic signed [DW+FRAC_W:0] p2_r;
  logic signed [QW-1:0]    qn_r;

  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic [SW-1:0]           srow;
  logic [SW-1:0]           nrow;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           addr;
  logic signed [QW-1:0]    rd_val;
  logic signed [RWD_W-1:0] reward_s;
  logic signed [QW:0]      g_term;
  logic signed [DW-1:0]    delta_nxt;
  logic signed [DW:0]      a_term;
  logic signed [DW+1:0]    qsum;
  logic signed [QW-1:0]    qn_nxt;
  logic [ACT_W-1:0]        best;
  logic signed [QW-1:0]    best_val;
  logic                    explore;
  out_item_t               res;

  // Table addressing: one port shared by reads and the write-back.
  assign srow    = row_wrap(in_r.state_index);
  assign nrow    = row_wrap(in_r.next_state_index);
  assign wr_addr = {srow, in_r.action_taken};
  assign rd_addr = cmd.rd_q ? {srow, in_r.action_taken} : {nrow, cmd.rd_slot};
  assign addr    = cmd.wr_en ? wr_addr : rd_addr;

  // An entry never written since reset reads as zero.
  assign rd_val = rd_vld_r ? rd_data_r : '0;

  // Q table storage with a registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= qn_nxt;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[addr];
      rd_vld_r  <= vld_r[addr];
    end
  end

  // Valid bits, cleared together at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (cmd.wr_en) begin
      vld_r[addr] <= 1'b1;
    end
  end

  // Configuration registers and the random generator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r   <= LR_RESET;
      disc_r <= DISC_RESET;
      thr_r  <= THR_RESET;
      lfsr_r <= SEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LEARNING_RATE:     lr_r   <= cfg_data[FRAC_W-1:0];
        CFG_DISCOUNT:          disc_r <= cfg_data[FRAC_W-1:0];
        CFG_EXPLORE_THRESHOLD: thr_r  <= cfg_data[FRAC_W-1:0];
        CFG_RNG_SEED:          lfsr_r <= (cfg_data != '0) ? cfg_data : 32'd1;
        default:               lr_r   <= lr_r;
      endcase
    end else if (cmd.lfsr_step) begin
      lfsr_r <= lfsr_next(lfsr_r);
    end
  end

  // Update arithmetic: target, delta, scaled step and saturation.
  assign reward_s  = in_r.reward;
  assign g_term    = p1_r[QW+FRAC_W:FRAC_W];
  assign delta_nxt = DW'(reward_s) + DW'(g_term) - DW'(q_r);
  assign a_term    = p2_r[DW+FRAC_W:FRAC_W];
  assign qsum      = (DW+2)'(q_r) + (DW+2)'(a_term);

  always_comb begin
    if ((qsum[DW+1:QW-1] == '0) || (qsum[DW+1:QW-1] == '1)) begin
      qn_nxt = qsum[QW-1:0];
    end else if (qsum[DW+1]) begin
      qn_nxt = {1'b1, {(QW-1){1'b0}}};
    end else begin
      qn_nxt = {1'b0, {(QW-1){1'b1}}};
    end
  end

  // Item capture, row cache, running maximum and the multiply stages.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.cap_en) begin
      cache_r[cmd.cap_slot] <= rd_val;
      if (cmd.cap_slot == 2'd0 || rd_val > mx_r) begin
        mx_r <= rd_val;
      end
    end
    if (cmd.cap_q) begin
      q_r <= rd_val;
    end
    if (cmd.mul1) begin
      p1_r <= mx_r * $signed({1'b0, disc_r});
    end
    if (cmd.calc_delta) begin
      delta_r <= delta_nxt;
    end
    if (cmd.mul2) begin
      p2_r <= delta_r * $signed({1'b0, lr_r});
    end
    if (cmd.wr_en) begin
      qn_r <= qn_nxt;
      // Keep the cached row current when the updated entry lies in it.
      if (srow == nrow) begin
        cache_r[in_r.action_taken] <= qn_nxt;
      end
    end
  end

  // Action choice: argmax with ties to the lowest index, or a random action.
  always_comb begin
    best     = '0;
    best_val = cache_r[0];
    for (int k = 1; k < ACTIONS; k++) begin
      if (cache_r[k] > best_val) begin
        best     = ACT_W'(k);
        best_val = cache_r[k];
      end
    end
  end

  assign explore           = (lfsr_r[31:16] < thr_r);
  assign res.chosen_action = explore ? lfsr_r[ACT_W-1:0] : best;
  assign res.explored      = explore;
  assign res.new_q_value   = q_to_out(in_r.do_update ? qn_r : q_r);

  // Output register; a waiting result holds until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.do_update = in_r.do_update;
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

[rtl/core/tabular_q_learning_agent.sv]
// Tabular Q-learning engine with epsilon-greedy action selection.
// Input channel (in_valid, in_stall, in_data) carries one transition per
// transfer: state, action, reward, next state and an update flag. Output
// channel (out_valid, out_stall, out_data) returns one result per item:
// the chosen action, whether it was random, and the Q entry, updated if asked.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes alpha, gamma, the explore threshold or the generator seed; it is
// always ready. The user is to write it only while the engine is idle;
// the block itself does not enforce this. Items are handled one at a time,
// in sequence through the single-port Q table: four reads of the next
// state's row, one read of the updated entry, the first of two multiply
// stages, and with an update the delta, the second multiply stage and
// the write-back.
// in_stall is low only while the engine is idle.
// A finished result sits in the output register; while the receiver
// stalls, the engine waits with the next result and takes no new item.
// Reset clears all Q table valid bits at once, restores the default alpha,
// gamma and threshold, and loads the generator with 1.
module tabular_q_learning_agent (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tqla_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tqla_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import tqla_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       cfg_we;

  // Register writes complete on every valid cycle.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  tqla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tqla_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
